>>> sv/rlle_pkg.sv
// Shared constants and types for the raster line run-length encoder.
package rlle_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 16;
  localparam int MAX_RUN   = 128;
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int MAX_BYTES = 4;
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic [COL_W-1:0] LINE_WIDTH_RESET = COL_W'(2550);
  localparam logic [PIX_W-1:0] LINE_MARKER      = '0;

  // Up to four encoded bytes produced by one pixel, in emission order.
  typedef struct packed {
    logic [MAX_BYTES-1:0][PIX_W-1:0] data;
    logic [CNT_W-1:0]                count;
  } bundle_t;

endpackage

>>> sv/rlle_core.sv
// Input register, run state and the per-pixel encode logic.
module rlle_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [rlle_pkg::PIX_W-1:0] in_pixel,
  output logic                      in_stall,
  input  logic [rlle_pkg::COL_W-1:0] line_width,
  output rlle_pkg::bundle_t         bundle,
  output logic                      bundle_valid,
  input  logic                      bundle_ready
);
  import rlle_pkg::*;

  logic               pix_valid_r;
  logic [PIX_W-1:0]   pix_r;
  logic [PIX_W-1:0]   run_value_r, run_value_nxt;
  logic [RUN_W-1:0]   run_count_r, run_count_nxt;
  logic [COL_W-1:0]   column_r, column_nxt;

  logic               line_start;
  logic               flush_old;
  logic               flush_new;
  logic               eol;
  logic [RUN_W-1:0]   cnt_a;
  logic [PIX_W-1:0]   val_a;
  logic [COL_W:0]     col_inc;
  logic [COL_W:0]     width_full;
  logic [PIX_W-1:0]   old_code;
  logic [PIX_W-1:0]   new_code;
  logic               advance;
  logic               has_bytes;

  always_comb begin
    line_start = (column_r == '0);
    flush_old  = (run_count_r != '0) && (pix_r != run_value_r);
    if ((run_count_r == '0) || flush_old) begin
      cnt_a = RUN_W'(1);
      val_a = pix_r;
    end else begin
      cnt_a = run_count_r + RUN_W'(1);
      val_a = run_value_r;
    end
    // A programmed width of zero stands for a full 65536-pixel line.
    col_inc    = {1'b0, column_r} + (COL_W+1)'(1);
    width_full = (line_width == '0) ? {1'b1, {COL_W{1'b0}}} : {1'b0, line_width};
    eol        = (col_inc >= width_full);
    flush_new  = (cnt_a >= RUN_W'(MAX_RUN)) || eol;

    old_code = PIX_W'(run_count_r - RUN_W'(1));
    new_code = PIX_W'(cnt_a - RUN_W'(1));

    run_value_nxt = val_a;
    run_count_nxt = flush_new ? '0 : cnt_a;
    column_nxt    = eol ? '0 : col_inc[COL_W-1:0];

    // A line start always has the run closed, so the marker never meets a
    // flush of the previous run.
    bundle.data = '0;
    unique case ({line_start, flush_old, flush_new})
      3'b000: begin
        bundle.count = CNT_W'(0);
      end
      3'b001: begin
        bundle.data[0] = new_code;
        bundle.data[1] = val_a;
        bundle.count   = CNT_W'(2);
      end
      3'b010: begin
        bundle.data[0] = old_code;
        bundle.data[1] = run_value_r;
        bundle.count   = CNT_W'(2);
      end
      3'b011: begin
        bundle.data[0] = old_code;
        bundle.data[1] = run_value_r;
        bundle.data[2] = new_code;
        bundle.data[3] = val_a;
        bundle.count   = CNT_W'(4);
      end
      3'b100: begin
        bundle.data[0] = LINE_MARKER;
        bundle.count   = CNT_W'(1);
      end
      default: begin
        bundle.data[0] = LINE_MARKER;
        bundle.data[1] = new_code;
        bundle.data[2] = val_a;
        bundle.count   = CNT_W'(3);
      end
    endcase

    has_bytes    = (bundle.count != '0);
    advance      = pix_valid_r && (!has_bytes || bundle_ready);
    bundle_valid = pix_valid_r && has_bytes && bundle_ready;
    in_stall     = pix_valid_r && !advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_valid_r <= 1'b0;
      run_value_r <= '0;
      run_count_r <= '0;
      column_r    <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        pix_valid_r <= 1'b1;
      end else if (advance) begin
        pix_valid_r <= 1'b0;
      end
      if (advance) begin
        run_value_r <= run_value_nxt;
        run_count_r <= run_count_nxt;
        column_r    <= column_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pix_r <= in_pixel;
    end
  end

endmodule

>>> sv/rlle_serializer.sv
// Result register that sends a pixel's encoded bytes one transfer at a time.
module rlle_serializer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rlle_pkg::bundle_t          bundle,
  input  logic                       bundle_valid,
  output logic                       bundle_ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rlle_pkg::PIX_W-1:0] out_byte,
  output logic                       out_last
);
  import rlle_pkg::*;

  bundle_t          bundle_r;
  logic             valid_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] last_pos;
  logic             xfer;

  always_comb begin
    last_pos     = bundle_r.count - CNT_W'(1);
    out_valid    = valid_r;
    out_byte     = bundle_r.data[idx_r];
    out_last     = (idx_r == last_pos[IDX_W-1:0]);
    xfer         = valid_r && !out_stall;
    bundle_ready = !valid_r || (xfer && out_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (bundle_valid) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (xfer) begin
      if (out_last) begin
        valid_r <= 1'b0;
        idx_r   <= '0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_valid) begin
      bundle_r <= bundle;
    end
  end

endmodule

>>> sv/raster_line_run_length_encoder.sv
// Top level of the raster line run-length encoder.
// This block encodes 8-bit gray pixels, arriving in raster order, into a byte
// stream: each line opens with a line marker byte of 0, and every run of equal
// pixels (at most 128 long, never crossing a line end) becomes the pair of
// run length minus one followed by the pixel value. The line width is set
// through the cfg_ port (0 means 65536 pixels) and must only be written while
// the block is idle; cfg_ready is always high. A pixel is taken into an input
// register, its encoded bytes are formed combinationally and loaded into a
// result register, and from there they leave one byte per output transfer,
// with out_last marking the final byte a pixel caused. The single byte-wide
// output sets the rate: a pixel that only extends the open run yields no
// bytes, while a pixel that yields bytes holds the output until each of them
// has been transferred, and its bytes pass from the input register through
// the result register to the output. A new pixel is taken while the previous
// pixel's bytes are still being sent.
module raster_line_run_length_encoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [rlle_pkg::PIX_W-1:0] in_pixel,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rlle_pkg::PIX_W-1:0] out_byte,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rlle_pkg::COL_W-1:0] cfg_data
);
  import rlle_pkg::*;

  logic [COL_W-1:0] line_width_r;
  bundle_t          bundle;
  logic             bundle_valid;
  logic             bundle_ready;

  // The width register accepts a write on every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_width_r <= cfg_data;
    end
  end

  // Run tracking and byte formation for one pixel per cycle unless in_stall holds the input.
  rlle_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_pixel     (in_pixel),
    .in_stall     (in_stall),
    .line_width   (line_width_r),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready)
  );

  // Holds one pixel's bytes and sends them out in order.
  rlle_serializer u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .bundle       (bundle),
    .bundle_valid (bundle_valid),
    .bundle_ready (bundle_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

endmodule

>>> sv/rlle_checker.sv
// Port-level assertions for the raster line run-length encoder, with its bind.
module rlle_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rlle_pkg::PIX_W-1:0] out_byte,
  input logic                       out_last
);

  // A stalled output byte stays in place with its marker.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output transfer changed while stalled");

  // Reset leaves no output pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // With the result register empty, the input side is never held off.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no output pending");

endmodule

bind raster_line_run_length_encoder rlle_checker u_rlle_checker (.*);
